### rtl/core/sobel_pkg.sv
// ----------------------------------------------------------------------------
// sobel_pkg
// Shared constants, register indexes and range helpers for the 3x3 Sobel
// gradient block.
// ----------------------------------------------------------------------------
package sobel_pkg;

	localparam int MAX_WIDTH    = 1024;
	localparam int HEIGHT_LIMIT = 4096;

	localparam int PIX_W    = 8;
	localparam int WIDTH_W  = 11;
	localparam int HEIGHT_W = 13;
	localparam int GRAD_W   = 11;
	localparam int COL_W    = $clog2(MAX_WIDTH);
	localparam int CNT_W    = (COL_W + 1 > WIDTH_W) ? COL_W + 1 : WIDTH_W;
	localparam int SLOT_W   = $clog2(MAX_WIDTH * (HEIGHT_LIMIT + 1) + 1);
	localparam int SUM_W    = PIX_W + 2;

	localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);
	localparam logic [SLOT_W-1:0]   PIXELS_RESET = SLOT_W'(640 * 480);

	// Register indexes, selected by paddr[2].
	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	// Item kinds on the input tuser bit.
	localparam logic ACT_PIXEL = 1'b0;
	localparam logic ACT_DRAIN = 1'b1;

	function automatic logic [WIDTH_W-1:0] clamp_width(input logic [WIDTH_W-1:0] w);
		logic [WIDTH_W-1:0] r;
		r = w;
		if (w == '0) begin
			r = WIDTH_W'(1);
		end else if (int'(w) > MAX_WIDTH) begin
			r = WIDTH_W'(MAX_WIDTH);
		end
		return r;
	endfunction

	function automatic logic [HEIGHT_W-1:0] clamp_height(input logic [HEIGHT_W-1:0] h);
		logic [HEIGHT_W-1:0] r;
		r = h;
		if (h == '0) begin
			r = HEIGHT_W'(1);
		end else if (int'(h) > HEIGHT_LIMIT) begin
			r = HEIGHT_W'(HEIGHT_LIMIT);
		end
		return r;
	endfunction

endpackage

### rtl/core/sobel_gradient_3x3.sv
// ----------------------------------------------------------------------------
// sobel_gradient_3x3
// Streaming 3x3 Sobel operator: raster pixels in, horizontal and vertical
// gradients out, one row plus one column behind, with zero outside the frame.
// ----------------------------------------------------------------------------
//  Channel   | Signals                          | Content
//  ----------+----------------------------------+------------------------------
//  s_axis    | tvalid tready tdata[7:0] tuser   | pixel; tuser = drain flag
//  m_axis    | tvalid tready tdata[23:0] tlast  | grad_x, grad_y; tlast = last
//  APB       | psel penable pwrite paddr[2:0]   | 0: frame_width 4: frame_height
//
//  One beat is taken per clock; the output register and the read stage give
//  two beats of slack, so the input stalls only when both are full and the
//  output is held. An accepted pixel and its registered line store read sit
//  in the read stage; the window and gradient adders feed the output register.
//  Reset clears position and window and sets the frame size to 640x480; the
//  line stores need no clearing, since rows above the frame are forced to zero.
// ----------------------------------------------------------------------------
module sobel_gradient_3x3 (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] pixel
	input  logic [0:0]  s_axis_tuser,   // [0] action

	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [10:0] grad_x, [21:11] grad_y, [23:22] zero
	output logic        m_axis_tlast,   // frame_last

	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int PIX_W  = sobel_pkg::PIX_W;
	localparam int COL_W  = sobel_pkg::COL_W;
	localparam int CNT_W  = sobel_pkg::CNT_W;
	localparam int SLOT_W = sobel_pkg::SLOT_W;
	localparam int GRAD_W = sobel_pkg::GRAD_W;
	localparam int SUM_W  = sobel_pkg::SUM_W;

	// Configuration.
	logic [sobel_pkg::WIDTH_W-1:0]  width_q;
	logic [sobel_pkg::HEIGHT_W-1:0] height_q;
	logic [SLOT_W-1:0]              pixels_q;
	logic                           cfg_wr;
	logic [sobel_pkg::WIDTH_W-1:0]  wc;
	logic [sobel_pkg::WIDTH_W-1:0]  wc_new;
	logic [sobel_pkg::HEIGHT_W-1:0] hc;
	logic [sobel_pkg::HEIGHT_W-1:0] hc_new;

	// Frame position.
	logic [SLOT_W-1:0] slot_q;
	logic [COL_W-1:0]  col_q;
	logic [1:0]        row_q;    // saturates at two

	// Line stores.
	logic [PIX_W-1:0] store_a [sobel_pkg::MAX_WIDTH];
	logic [PIX_W-1:0] store_b [sobel_pkg::MAX_WIDTH];

	// Read stage.
	logic              s1_v_q;
	logic [COL_W-1:0]  c_s1;
	logic [PIX_W-1:0]  v_s1;
	logic              emit_s1;
	logic              last_s1;
	logic              top_ok_s1;
	logic              mid_ok_s1;
	logic              fwd_s1;
	logic [PIX_W-1:0]  fwd_a_s1;
	logic [PIX_W-1:0]  fwd_b_s1;
	logic [PIX_W-1:0]  rd_a_s1;
	logic [PIX_W-1:0]  rd_b_s1;

	// Window, columns one and two of each row.
	logic [PIX_W-1:0] win1_q [3];
	logic [PIX_W-1:0] win2_q [3];

	// Output register.
	logic              out_v_q;
	logic [GRAD_W-1:0] gx_q;
	logic [GRAD_W-1:0] gy_q;
	logic              last_q;

	// Accept-side decode.
	logic              accept;
	logic              drain;
	logic              in_frame;
	logic              ignore;
	logic              take;
	logic [COL_W-1:0]  c0;
	logic [CNT_W-1:0]  ncol;
	logic [PIX_W-1:0]  v0;
	logic              last0;
	logic              emit0;

	// Read stage logic.
	logic              out_free;
	logic              s1_go;
	logic              c_zero;
	logic [PIX_W-1:0]  a_old;
	logic [PIX_W-1:0]  b_old;
	logic [PIX_W-1:0]  fresh [3];
	logic [PIX_W-1:0]  col2 [3];
	logic [SUM_W-1:0]  sx_pos, sx_neg, sy_pos, sy_neg;
	logic [GRAD_W-1:0] gx, gy;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign wc     = sobel_pkg::clamp_width(width_q);
	assign hc     = sobel_pkg::clamp_height(height_q);
	assign wc_new = sobel_pkg::clamp_width(pwdata[sobel_pkg::WIDTH_W-1:0]);
	assign hc_new = sobel_pkg::clamp_height(pwdata[sobel_pkg::HEIGHT_W-1:0]);

	always_comb begin
		unique case (paddr[2])
			sobel_pkg::REG_FRAME_WIDTH:  prdata = 32'(width_q);
			sobel_pkg::REG_FRAME_HEIGHT: prdata = 32'(height_q);
			default:                     prdata = '0;
		endcase
	end

	// The frame size in pixels is refreshed with each register write, so the
	// multiplier sits on the register path only.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= sobel_pkg::WIDTH_RESET;
			height_q <= sobel_pkg::HEIGHT_RESET;
			pixels_q <= sobel_pkg::PIXELS_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				sobel_pkg::REG_FRAME_WIDTH: begin
					width_q  <= pwdata[sobel_pkg::WIDTH_W-1:0];
					pixels_q <= SLOT_W'(wc_new * hc);
				end
				sobel_pkg::REG_FRAME_HEIGHT: begin
					height_q <= pwdata[sobel_pkg::HEIGHT_W-1:0];
					pixels_q <= SLOT_W'(wc * hc_new);
				end
				default: begin
				end
			endcase
		end
	end

	// ---------------- accept side ----------------
	assign out_free      = !out_v_q || m_axis_tready;
	assign s1_go         = s1_v_q && (!emit_s1 || out_free);
	assign s_axis_tready = !s1_v_q || s1_go;
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign drain    = (s_axis_tuser[0] == sobel_pkg::ACT_DRAIN);
	assign in_frame = slot_q < pixels_q;
	assign ignore   = drain && in_frame;
	assign take     = accept && !ignore;
	assign c0       = (CNT_W'(col_q) >= CNT_W'(wc)) ? '0 : col_q;
	assign ncol     = CNT_W'(c0) + CNT_W'(1);
	assign v0       = (drain || !in_frame) ? '0 : s_axis_tdata[PIX_W-1:0];
	assign last0    = slot_q >= (pixels_q + SLOT_W'(wc));
	assign emit0    = slot_q >= (SLOT_W'(wc) + SLOT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			col_q  <= '0;
			row_q  <= '0;
		end else if (accept) begin
			if (ignore) begin
				col_q <= c0;
			end else if (last0) begin
				slot_q <= '0;
				col_q  <= '0;
				row_q  <= '0;
			end else begin
				slot_q <= slot_q + SLOT_W'(1);
				if (ncol >= CNT_W'(wc)) begin
					col_q <= '0;
					if (row_q != 2'd2) begin
						row_q <= row_q + 2'd1;
					end
				end else begin
					col_q <= ncol[COL_W-1:0];
				end
			end
		end
	end

	// ---------------- line stores ----------------
	always_ff @(posedge clk) begin
		if (take) begin
			rd_a_s1 <= store_a[c0];
			rd_b_s1 <= store_b[c0];
		end
		if (s1_go) begin
			store_a[c_s1] <= v_s1;
			store_b[c_s1] <= a_old;
		end
	end

	// ---------------- read stage ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (take) begin
			s1_v_q <= 1'b1;
		end else if (s1_go) begin
			s1_v_q <= 1'b0;
		end
	end

	// A write of the same column in the cycle of the read is not seen by the
	// store, so its data are kept beside the read data.
	always_ff @(posedge clk) begin
		if (take) begin
			c_s1      <= c0;
			v_s1      <= v0;
			emit_s1   <= emit0;
			last_s1   <= last0;
			top_ok_s1 <= (row_q == 2'd2);
			mid_ok_s1 <= (row_q != 2'd0);
			fwd_s1    <= s1_go && (c_s1 == c0);
			fwd_a_s1  <= v_s1;
			fwd_b_s1  <= a_old;
		end
	end

	assign a_old  = fwd_s1 ? fwd_a_s1 : rd_a_s1;
	assign b_old  = fwd_s1 ? fwd_b_s1 : rd_b_s1;
	assign c_zero = (c_s1 == '0);

	assign fresh[0] = top_ok_s1 ? b_old : '0;
	assign fresh[1] = mid_ok_s1 ? a_old : '0;
	assign fresh[2] = v_s1;

	// At column zero the right column lies outside the frame.
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			col2[r] = c_zero ? '0 : fresh[r];
		end
	end

	assign sx_pos = SUM_W'(col2[0]) + {1'b0, col2[1], 1'b0} + SUM_W'(col2[2]);
	assign sx_neg = SUM_W'(win1_q[0]) + {1'b0, win1_q[1], 1'b0} + SUM_W'(win1_q[2]);
	assign sy_pos = SUM_W'(win1_q[2]) + {1'b0, win2_q[2], 1'b0} + SUM_W'(col2[2]);
	assign sy_neg = SUM_W'(win1_q[0]) + {1'b0, win2_q[0], 1'b0} + SUM_W'(col2[0]);
	assign gx     = GRAD_W'(sx_pos) - GRAD_W'(sx_neg);
	assign gy     = GRAD_W'(sy_pos) - GRAD_W'(sy_neg);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				win1_q[r] <= '0;
				win2_q[r] <= '0;
			end
		end else if (s1_go) begin
			for (int r = 0; r < 3; r++) begin
				if (last_s1) begin
					win1_q[r] <= '0;
					win2_q[r] <= '0;
				end else begin
					win1_q[r] <= c_zero ? '0 : win2_q[r];
					win2_q[r] <= fresh[r];
				end
			end
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (s1_go && emit_s1) begin
			out_v_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && emit_s1) begin
			gx_q   <= gx;
			gy_q   <= gy;
			last_q <= last_s1;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {2'b00, gy_q, gx_q};
	assign m_axis_tlast  = last_q;

	// ---------------- assertions ----------------
	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(take && last0) |=> (slot_q == '0 && col_q == '0 && row_q == 2'd0))
		else $error("position not cleared after the last beat of a frame");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (s1_v_q && out_v_q && emit_s1))
		else $error("input stalled while a stage had room");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_v_q) |-> $past(s1_v_q && emit_s1))
		else $error("result appeared without an emitting item in the read stage");

	a_column_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		s1_v_q |-> (CNT_W'(c_s1) < CNT_W'(wc)))
		else $error("line store column beyond the frame width");

endmodule
